// ===== rtl/fsp_pkg.sv =====
// Package with the types, codes and defaults of the frame section profiler.
package fsp_pkg;

	localparam int SECTION_COUNT_DEF = 4;
	localparam logic [15:0] WINDOW_RESET = 16'd1000;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	localparam logic [2:0] CMD_FRAME_BEGIN = 3'd0;
	localparam logic [2:0] CMD_FRAME_END = 3'd1;
	localparam logic [2:0] CMD_SECTION_MARK = 3'd2;
	localparam logic [2:0] CMD_DRAW_CALL = 3'd3;
	localparam logic [2:0] CMD_ROUNDED_RECT = 3'd4;
	localparam logic [2:0] CMD_TEXTURE_BIND = 3'd5;

	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_SECTION = 1'b1;

	typedef struct packed {
		logic [2:0] command;
		logic [3:0] section;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic record_kind;
		logic [3:0] section_index;
		logic [31:0] frames_in_window;
		logic [31:0] avg_ms;
		logic [31:0] max_ms;
		logic [31:0] min_ms;
		logic [31:0] draw_calls_avg;
		logic [31:0] rounded_rects_avg;
		logic [31:0] texture_binds_avg;
		logic last;
	} record_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] fsum;
		logic [31:0] wsum;
		logic [31:0] peak;
	} sec_word_t;

endpackage

// ===== rtl/fsp_ram.sv =====
// Generic single-port-write, registered-read RAM.
module fsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/fsp_div.sv =====
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
module fsp_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] dividend,
	input logic [31:0] divisor,
	output logic done,
	output logic [31:0] quotient
);
	logic busy_q;
	logic done_q;
	logic [4:0] cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
			end
			quo_q <= {quo_q[30:0], ~trial[32]};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule

// ===== rtl/frame_section_profiler.sv =====
// Top level of the frame section profiler.
//
// The block takes one event per transfer, and only while it is idle. Frame
// begin and the three draw counters are handled in the idle state, a section
// mark reads, modifies and writes the section memory, and a frame end folds
// every section into the window totals, a read and a write per section. A
// frame end that closes the window then produces a report: four divisions and
// one send for the summary, then per section a read, a division and a send;
// each send waits while the output is stalled. Per-section state lives in one
// RAM with a registered read; flags clear it at frame begin and window close.
module frame_section_profiler #(
	parameter int SECTION_COUNT = fsp_pkg::SECTION_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [15:0] cfg_data,
	input logic item_valid,
	output logic item_ready,
	input fsp_pkg::item_t item,
	output logic rec_valid,
	input logic rec_ready,
	output fsp_pkg::record_t rec
);
	import fsp_pkg::*;

	localparam int SW = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;
	localparam logic [SW-1:0] LAST_SEC = SW'(SECTION_COUNT - 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MARK_RD = 4'd1;
	localparam logic [3:0] ST_MARK_WR = 4'd2;
	localparam logic [3:0] ST_FOLD_RD = 4'd3;
	localparam logic [3:0] ST_FOLD_WR = 4'd4;
	localparam logic [3:0] ST_CHECK = 4'd5;
	localparam logic [3:0] ST_DIV_GO = 4'd6;
	localparam logic [3:0] ST_DIV_WAIT = 4'd7;
	localparam logic [3:0] ST_SUM_SEND = 4'd8;
	localparam logic [3:0] ST_SEC_RD = 4'd9;
	localparam logic [3:0] ST_SEC_GO = 4'd10;
	localparam logic [3:0] ST_SEC_WAIT = 4'd11;
	localparam logic [3:0] ST_SEC_SEND = 4'd12;

	logic [3:0] state_q;
	logic [15:0] window_q;
	logic [31:0] now_q;
	logic [SW-1:0] addr_q;
	logic [1:0] sel_q;

	logic [31:0] fstart_q, fdraw_q, frnd_q, fbind_q;
	logic [31:0] wstart_q, wframes_q, wfsum_q, wfmax_q, wfmin_q;
	logic [31:0] wdraw_q, wrnd_q, wbind_q;
	logic [31:0] qframe_q, qdraw_q, qrnd_q, qbind_q;
	logic [SECTION_COUNT-1:0] running_q, fvalid_q, wvalid_q;

	record_t rec_q;
	logic rec_valid_q;
	logic out_free;
	logic rec_load;

	logic accept;
	logic [31:0] ft;
	logic sec_ok;

	sec_word_t rd_word, wr_word;
	logic [127:0] rd_raw;
	logic ram_we;
	logic [31:0] fsum_e, wsum_e, peak_e, fsum_new;

	logic div_start, div_done;
	logic [31:0] div_dividend, div_divisor, div_quo;

	assign accept = item_valid && item_ready;
	assign item_ready = (state_q == ST_IDLE);
	assign out_free = !rec_valid_q || rec_ready;
	assign rec_load = out_free && ((state_q == ST_SUM_SEND) || (state_q == ST_SEC_SEND));
	assign ft = item.now_ms - fstart_q;
	assign sec_ok = {1'b0, item.section} < 5'(SECTION_COUNT);

	fsp_ram #(.WIDTH(128), .DEPTH(SECTION_COUNT)) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(addr_q),
		.wdata(wr_word),
		.raddr(addr_q),
		.rdata(rd_raw)
	);

	assign rd_word = sec_word_t'(rd_raw);
	assign fsum_e = fvalid_q[addr_q] ? rd_word.fsum : 32'd0;
	assign wsum_e = wvalid_q[addr_q] ? rd_word.wsum : 32'd0;
	assign peak_e = wvalid_q[addr_q] ? rd_word.peak : 32'd0;
	assign fsum_new = fsum_e + (now_q - rd_word.start);

	always_comb begin
		ram_we = 1'b0;
		wr_word = '{start: rd_word.start, fsum: fsum_e, wsum: wsum_e, peak: peak_e};
		case (state_q)
			ST_MARK_WR: begin
				ram_we = 1'b1;
				if (!running_q[addr_q]) begin
					wr_word.start = now_q;
				end else begin
					wr_word.fsum = fsum_new;
				end
			end
			ST_FOLD_WR: begin
				ram_we = 1'b1;
				wr_word.wsum = wsum_e + fsum_e;
				wr_word.peak = (fsum_e > peak_e) ? fsum_e : peak_e;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Frame count is at least one whenever a report runs.
	assign div_divisor = (wframes_q == 32'd0) ? 32'd1 : wframes_q;
	always_comb begin
		case (sel_q)
			2'd0: div_dividend = wfsum_q;
			2'd1: div_dividend = wdraw_q;
			2'd2: div_dividend = wrnd_q;
			default: div_dividend = wbind_q;
		endcase
		if (state_q == ST_SEC_GO) begin
			div_dividend = wsum_e;
		end
	end
	assign div_start = (state_q == ST_DIV_GO) || (state_q == ST_SEC_GO);

	fsp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.done(div_done),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			window_q <= WINDOW_RESET;
			now_q <= '0;
			addr_q <= '0;
			sel_q <= '0;
			fstart_q <= '0;
			fdraw_q <= '0;
			frnd_q <= '0;
			fbind_q <= '0;
			wstart_q <= '0;
			wframes_q <= '0;
			wfsum_q <= '0;
			wfmax_q <= '0;
			wfmin_q <= ALL_ONES;
			wdraw_q <= '0;
			wrnd_q <= '0;
			wbind_q <= '0;
			qframe_q <= '0;
			qdraw_q <= '0;
			qrnd_q <= '0;
			qbind_q <= '0;
			running_q <= '0;
			fvalid_q <= '0;
			wvalid_q <= '0;
			rec_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_data;
			end
			if (rec_valid_q && rec_ready && !rec_load) begin
				rec_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						now_q <= item.now_ms;
						case (item.command)
							CMD_FRAME_BEGIN: begin
								fstart_q <= item.now_ms;
								fdraw_q <= '0;
								frnd_q <= '0;
								fbind_q <= '0;
								running_q <= '0;
								fvalid_q <= '0;
							end
							CMD_FRAME_END: begin
								wframes_q <= wframes_q + 32'd1;
								wfsum_q <= wfsum_q + ft;
								if (ft > wfmax_q) wfmax_q <= ft;
								if (ft < wfmin_q) wfmin_q <= ft;
								wdraw_q <= wdraw_q + fdraw_q;
								wrnd_q <= wrnd_q + frnd_q;
								wbind_q <= wbind_q + fbind_q;
								addr_q <= '0;
								state_q <= ST_FOLD_RD;
							end
							CMD_SECTION_MARK: begin
								if (sec_ok) begin
									addr_q <= item.section[SW-1:0];
									state_q <= ST_MARK_RD;
								end
							end
							CMD_DRAW_CALL: fdraw_q <= fdraw_q + 32'd1;
							CMD_ROUNDED_RECT: frnd_q <= frnd_q + 32'd1;
							CMD_TEXTURE_BIND: fbind_q <= fbind_q + 32'd1;
							default: begin
							end
						endcase
					end
				end
				ST_MARK_RD: state_q <= ST_MARK_WR;
				ST_MARK_WR: begin
					running_q[addr_q] <= !running_q[addr_q];
					fvalid_q[addr_q] <= 1'b1;
					wvalid_q[addr_q] <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_FOLD_RD: state_q <= ST_FOLD_WR;
				ST_FOLD_WR: begin
					fvalid_q[addr_q] <= 1'b1;
					wvalid_q[addr_q] <= 1'b1;
					if (addr_q == LAST_SEC) begin
						state_q <= ST_CHECK;
					end else begin
						addr_q <= addr_q + SW'(1);
						state_q <= ST_FOLD_RD;
					end
				end
				ST_CHECK: begin
					sel_q <= '0;
					addr_q <= '0;
					if ((now_q - wstart_q) >= {16'd0, window_q}) begin
						state_q <= ST_DIV_GO;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done) begin
						case (sel_q)
							2'd0: qframe_q <= div_quo;
							2'd1: qdraw_q <= div_quo;
							2'd2: qrnd_q <= div_quo;
							default: qbind_q <= div_quo;
						endcase
						sel_q <= sel_q + 2'd1;
						state_q <= (sel_q == 2'd3) ? ST_SUM_SEND : ST_DIV_GO;
					end
				end
				ST_SUM_SEND: begin
					if (out_free) begin
						rec_valid_q <= 1'b1;
						state_q <= ST_SEC_RD;
					end
				end
				ST_SEC_RD: state_q <= ST_SEC_GO;
				ST_SEC_GO: state_q <= ST_SEC_WAIT;
				ST_SEC_WAIT: begin
					if (div_done) begin
						state_q <= ST_SEC_SEND;
					end
				end
				ST_SEC_SEND: begin
					if (out_free) begin
						rec_valid_q <= 1'b1;
						if (addr_q == LAST_SEC) begin
							wstart_q <= now_q;
							wframes_q <= '0;
							wfsum_q <= '0;
							wfmax_q <= '0;
							wfmin_q <= ALL_ONES;
							wdraw_q <= '0;
							wrnd_q <= '0;
							wbind_q <= '0;
							wvalid_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							addr_q <= addr_q + SW'(1);
							state_q <= ST_SEC_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The divider holds its quotient until the next start, so the section send
	// state can take it directly.
	always_ff @(posedge clk) begin
		if (state_q == ST_SUM_SEND && out_free) begin
			rec_q <= '{record_kind: KIND_SUMMARY, section_index: 4'd0,
				frames_in_window: wframes_q, avg_ms: qframe_q, max_ms: wfmax_q,
				min_ms: wfmin_q, draw_calls_avg: qdraw_q, rounded_rects_avg: qrnd_q,
				texture_binds_avg: qbind_q, last: 1'b0};
		end else if (state_q == ST_SEC_SEND && out_free) begin
			rec_q <= '{record_kind: KIND_SECTION, section_index: 4'(addr_q),
				frames_in_window: wframes_q, avg_ms: div_quo, max_ms: peak_e,
				min_ms: 32'd0, draw_calls_avg: 32'd0, rounded_rects_avg: 32'd0,
				texture_binds_avg: 32'd0, last: (addr_q == LAST_SEC)};
		end
	end

	assign rec_valid = rec_valid_q;
	assign rec = rec_q;
endmodule
